@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; clk and rst are the module's clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pkhm_pkg.sv @@
// Types and constants for the pointer-keyed hash map.
`default_nettype none

package pkhm_pkg;

  // Commands
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [1:0] CMD_RESOLVE = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISS     = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_ZERO_KEY = 2'd3;

  // Hash: shift-xor, multiply, shift-xor
  localparam int          HASH_SHIFT = 16;
  localparam int          MUL_W      = 27;
  localparam logic [26:0] HASH_MUL   = 27'h45d9f3b;

  // Load limit: new keys refused once count * LOAD_DEN >= slots * LOAD_NUM
  localparam int LOAD_NUM = 7;
  localparam int LOAD_DEN = 10;

  localparam int SLOT_OUT_W = 12;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [9:0]  mod_idx;
    logic [63:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [9:0]            found_module;
    logic                  is_resolved;
    logic [63:0]           found_handle;
    logic [SLOT_OUT_W-1:0] slot_used;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key;
    logic [9:0]  mod_idx;
    logic        resolved;
    logic [63:0] handle;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_PROBE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/pointer_keyed_hash_map.sv @@
// Pointer-keyed hash map: open-addressing table with linear probing, top level.
//
// Command channel: an item (cmd, key, mod_idx, handle) is taken at a rising edge
// with start high and busy low. Each item yields one result on result, marked by done
// for exactly one cycle; the receiver cannot stall, so results are never held.
// Sequence: an accepted item passes through ST_HASH1 and ST_HASH2 (with the split multiply),
// then ST_PROBE with one table read per probed slot; no new item is taken until it is done,
// and the result strobe rises in the cycle in which busy falls. A zero key or an unknown
// command is answered in the cycle after acceptance and busy stays low.
// The single table memory (key, module, resolved mark, handle per slot) with its one
// read port sets the probe rate of one slot per cycle.
// Reset: rst is synchronous; afterwards a clearing pass writes every slot empty, all SLOTS
// of them (4096 at the default), with busy high, then the block goes idle.
// A new key is refused with status full once the entry count reaches 70% of SLOTS.
`default_nettype none
`include "assert_macros.svh"

module pointer_keyed_hash_map
  import pkhm_pkg::*;
#(
  parameter int SLOTS = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire in_item_t  item,
  output logic           busy,
  output logic           done,
  output out_item_t      result
);

  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int PW         = SLOT_W + HASH_SHIFT;
  localparam int LO_W       = PW / 2;
  localparam int HI_W       = PW - LO_W;
  localparam int LOAD_LIMIT = (SLOTS * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN;

  state_t state, state_next;

  in_item_t                 req;
  logic [LO_W+MUL_W-1:0]    lo_prod;
  logic [HI_W+MUL_W-1:0]    hi_prod;
  logic [PW-1:0]            hv;
  logic [PW-1:0]            prod;
  logic [SLOT_W-1:0]        home_slot;
  logic [SLOT_W-1:0]        cur_slot;
  logic [SLOT_W-1:0]        probe_cnt;
  logic [SLOT_W-1:0]        clr_idx;
  logic [SLOT_W-1:0]        entry_count;

  entry_t                   mem [SLOTS];
  entry_t                   rd_data;
  entry_t                   wr_data;
  logic [SLOT_W-1:0]        rd_addr;
  logic [SLOT_W-1:0]        wr_addr;
  logic                     wr_en;

  logic                     done_next;
  out_item_t                res_next;
  logic                     cnt_inc;
  logic                     hit;
  logic                     empty;
  logic                     last;
  logic                     at_limit;

  assign busy = (state != ST_IDLE);

  // Only the bits that reach the slot index are hashed.
  assign hv        = req.key[PW-1:0] ^ req.key[PW+HASH_SHIFT-1:HASH_SHIFT];
  assign prod      = lo_prod[PW-1:0] + {hi_prod[HI_W-1:0], {LO_W{1'b0}}};
  assign home_slot = prod[SLOT_W-1:0] ^ prod[SLOT_W+HASH_SHIFT-1:HASH_SHIFT];

  assign hit      = (rd_data.key == req.key);
  assign empty    = (rd_data.key == 64'd0);
  assign last     = (probe_cnt == SLOT_W'(SLOTS - 1));
  assign at_limit = (entry_count >= SLOT_W'(LOAD_LIMIT));

  // Table memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    rd_addr    = cur_slot + 1'b1;
    wr_en      = 1'b0;
    wr_addr    = cur_slot;
    wr_data    = '0;
    done_next  = 1'b0;
    res_next   = '0;
    cnt_inc    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        if (clr_idx == SLOT_W'(SLOTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          priority if (item.key == 64'd0) begin
            done_next       = 1'b1;
            res_next.status = STATUS_ZERO_KEY;
          end else if (item.cmd == CMD_UNUSED) begin
            done_next       = 1'b1;
            res_next.status = STATUS_MISS;
          end else begin
            state_next = ST_HASH1;
          end
        end
      end
      ST_HASH1: state_next = ST_HASH2;
      ST_HASH2: begin
        rd_addr    = home_slot;
        state_next = ST_PROBE;
      end
      ST_PROBE: begin
        // rd_data holds cur_slot; the read of the following slot is already issued
        if (hit || empty || last) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
          priority if (req.cmd == CMD_INSERT) begin
            if (hit || (empty && !at_limit)) begin
              wr_en                 = 1'b1;
              wr_data.key           = req.key;
              wr_data.mod_idx       = req.mod_idx;
              cnt_inc               = !hit;
              res_next.status       = STATUS_OK;
              res_next.found_module = req.mod_idx;
              res_next.slot_used    = SLOT_OUT_W'(cur_slot);
            end else begin
              res_next.status = STATUS_FULL;
            end
          end else if (!hit) begin
            res_next.status = STATUS_MISS;
          end else if (req.cmd == CMD_RESOLVE) begin
            wr_en                 = 1'b1;
            wr_data               = rd_data;
            wr_data.resolved      = 1'b1;
            wr_data.handle        = req.handle;
            res_next.status       = STATUS_OK;
            res_next.found_module = rd_data.mod_idx;
            res_next.is_resolved  = 1'b1;
            res_next.found_handle = req.handle;
            res_next.slot_used    = SLOT_OUT_W'(cur_slot);
          end else begin
            res_next.status       = STATUS_OK;
            res_next.found_module = rd_data.mod_idx;
            res_next.is_resolved  = rd_data.resolved;
            res_next.found_handle = rd_data.resolved ? rd_data.handle : 64'd0;
            res_next.slot_used    = SLOT_OUT_W'(cur_slot);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (cnt_inc) entry_count <= entry_count + 1'b1;
    end
  end

  // Payload and probe registers
  always_ff @(posedge clk) begin
    if (done_next) result <= res_next;
    if (state == ST_IDLE && start) req <= item;
    if (state == ST_HASH1) begin
      lo_prod <= (LO_W+MUL_W)'(hv[LO_W-1:0]) * (LO_W+MUL_W)'(HASH_MUL);
      hi_prod <= (HI_W+MUL_W)'(hv[PW-1:LO_W]) * (HI_W+MUL_W)'(HASH_MUL);
    end
    if (state == ST_HASH2) begin
      cur_slot  <= home_slot;
      probe_cnt <= '0;
    end
    if (state == ST_PROBE) begin
      cur_slot  <= cur_slot + 1'b1;
      probe_cnt <= probe_cnt + 1'b1;
    end
  end

  `ASSERT_IMP(a_wr_state, wr_en, state == ST_PROBE || state == ST_CLEAR, "stray table write")
  `ASSERT_IMP(a_count_limit, 1'b1, entry_count <= SLOT_W'(LOAD_LIMIT), "count over limit")
  `ASSERT_NXT(a_start_hash,
              start && !busy && item.key != 64'd0 && item.cmd != CMD_UNUSED,
              state == ST_HASH1, "accepted item did not enter hashing")
  `ASSERT_NXT(a_probe_done, state == ST_PROBE && state_next == ST_IDLE, done, "no strobe")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the pointer-keyed hash map: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import pkhm_pkg::*;

  localparam int TABLE_SLOTS = 4096;
  localparam int STALL_LIMIT = 5 * (TABLE_SLOTS + 16);
  localparam int SETTLE_CYCLES = 16;
  localparam logic [63:0] ONES = '1;

  typedef enum logic [1:0] {PROBE_HIT, PROBE_EMPTY, PROBE_EXHAUSTED} probe_outcome_t;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  item = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  pointer_keyed_hash_map #(.SLOTS(TABLE_SLOTS)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table
  logic [63:0] slot_key    [TABLE_SLOTS] = '{default: '0};
  logic [9:0]  slot_module [TABLE_SLOTS] = '{default: '0};
  logic        slot_marked [TABLE_SLOTS] = '{default: '0};
  logic [63:0] slot_handle [TABLE_SLOTS] = '{default: '0};
  int          keys_held = 0;
  logic [63:0] known_keys[$];

  out_item_t answers_due[$];
  int        status_tally[4] = '{default: 0};
  int        items_sent = 0;
  int        answers_checked = 0;
  int        faults = 0;
  int        stall_cycles = 0;
  bit        gapless = 1'b0;

  function automatic logic [11:0] home_slot(logic [63:0] k);
    logic [63:0] v;
    v = k ^ (k >> 16);
    v = v * 64'h45d9f3b;
    v = v ^ (v >> 16);
    return v[11:0];
  endfunction

  function automatic out_item_t predict_answer(in_item_t it);
    out_item_t      ans;
    probe_outcome_t found;
    logic [11:0]    s;
    logic [11:0]    at;
    ans = '0;
    found = PROBE_EXHAUSTED;
    at = '0;
    if (it.key == '0) begin
      ans.status = STATUS_ZERO_KEY;
    end else if (it.cmd == CMD_UNUSED) begin
      ans.status = STATUS_MISS;
    end else begin
      s = home_slot(it.key);
      for (int i = 0; i < TABLE_SLOTS && found == PROBE_EXHAUSTED; i++) begin
        if (slot_key[s] == it.key) begin
          found = PROBE_HIT;
          at = s;
        end else if (slot_key[s] == '0) begin
          found = PROBE_EMPTY;
          at = s;
        end
        s = s + 1'b1;
      end
      if (it.cmd == CMD_INSERT) begin
        if (found == PROBE_HIT ||
            (found == PROBE_EMPTY && keys_held * LOAD_DEN < TABLE_SLOTS * LOAD_NUM)) begin
          if (found == PROBE_EMPTY) begin
            slot_key[at] = it.key;
            keys_held++;
            known_keys.push_back(it.key);
          end
          slot_module[at] = it.mod_idx;
          slot_marked[at] = 1'b0;
          slot_handle[at] = '0;
          ans.found_module = it.mod_idx;
          ans.slot_used = at;
        end else begin
          ans.status = STATUS_FULL;
        end
      end else if (found != PROBE_HIT) begin
        ans.status = STATUS_MISS;
      end else begin
        if (it.cmd == CMD_RESOLVE) begin
          slot_handle[at] = it.handle;
          slot_marked[at] = 1'b1;
        end
        ans.found_module = slot_module[at];
        ans.is_resolved = slot_marked[at];
        ans.found_handle = slot_marked[at] ? slot_handle[at] : '0;
        ans.slot_used = at;
      end
    end
    status_tally[ans.status]++;
    return ans;
  endfunction

  function automatic row_t mk_row(logic [1:0] c, logic [63:0] k, logic [9:0] m,
                                  logic [63:0] h, bit typed, logic [1:0] st);
    row_t r;
    r.stim.cmd = c;
    r.stim.key = k;
    r.stim.mod_idx = m;
    r.stim.handle = h;
    r.typed = typed;
    r.want = '0;
    r.want.status = st;
    return r;
  endfunction

  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    case ($urandom_range(0, 3))
      1: k = 64'($urandom_range(1, 4095));
      2: k = {$urandom, 32'h0};
      3: k = ~64'($urandom_range(0, 65535));
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  function automatic logic [63:0] pooled_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // insert_pct: share of inserts; new_pct: share of those using a fresh key
  function automatic in_item_t random_item(int insert_pct, int new_pct);
    in_item_t it;
    int       roll;
    roll = $urandom_range(0, 99);
    it.mod_idx = 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 7))
      0: it.handle = '0;
      1: it.handle = ONES;
      default: it.handle = {$urandom, $urandom};
    endcase
    it.key = fresh_key();
    if (roll < 3) begin
      it.cmd = 2'($urandom_range(0, 3));
      it.key = '0;
    end else if (roll < 6) begin
      it.cmd = CMD_UNUSED;
    end else if (roll < 6 + insert_pct) begin
      it.cmd = CMD_INSERT;
      if ($urandom_range(0, 99) >= new_pct && known_keys.size() != 0) it.key = pooled_key();
    end else begin
      it.cmd = $urandom_range(0, 1) ? CMD_RESOLVE : CMD_LOOKUP;
      if ($urandom_range(0, 99) < 85 && known_keys.size() != 0) it.key = pooled_key();
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with start still high.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int        gap;
    out_item_t ans;
    if ($urandom_range(0, 63) == 0) gapless = !gapless;
    gap = gapless ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    ans = predict_answer(it);
    answers_due.push_back(typed ? want : ans);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (answers_due.size() != 0);
  endtask

  task automatic check_answer(out_item_t got);
    out_item_t want;
    if (answers_due.size() == 0) begin
      $error("result with no item outstanding: %h", got);
      faults++;
      return;
    end
    want = answers_due.pop_front();
    answers_checked++;
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      faults++;
    end
    if (got.found_module !== want.found_module) begin
      $error("found_module: expected %0d, got %0d", want.found_module, got.found_module);
      faults++;
    end
    if (got.is_resolved !== want.is_resolved) begin
      $error("is_resolved: expected %0b, got %0b", want.is_resolved, got.is_resolved);
      faults++;
    end
    if (got.found_handle !== want.found_handle) begin
      $error("found_handle: expected %h, got %h", want.found_handle, got.found_handle);
      faults++;
    end
    if (got.slot_used !== want.slot_used) begin
      $error("slot_used: expected %0d, got %0d", want.slot_used, got.slot_used);
      faults++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) check_answer(result);
  end

  // Covers the clearing pass after reset and the longest probe
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL pointer_keyed_hash_map");
      $finish;
    end
  end

  initial begin
    row_t plan[$];
    plan.push_back(mk_row(CMD_INSERT,  64'd0, 10'd1023, ONES, 1'b1, STATUS_ZERO_KEY));
    plan.push_back(mk_row(CMD_LOOKUP,  64'd0, 10'd0,    '0,   1'b1, STATUS_ZERO_KEY));
    plan.push_back(mk_row(CMD_RESOLVE, 64'd0, 10'd0,    ONES, 1'b1, STATUS_ZERO_KEY));
    plan.push_back(mk_row(CMD_UNUSED,  64'd0, 10'd0,    '0,   1'b1, STATUS_ZERO_KEY));
    plan.push_back(mk_row(CMD_UNUSED,  ONES,  10'd1023, ONES, 1'b1, STATUS_MISS));
    plan.push_back(mk_row(CMD_LOOKUP,  ONES,  10'd0,    '0,   1'b1, STATUS_MISS));
    plan.push_back(mk_row(CMD_RESOLVE, ONES,  10'd0,    ONES, 1'b1, STATUS_MISS));
    plan.push_back(mk_row(CMD_INSERT,  ONES,  10'd1023, ONES, 1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_INSERT,  64'd1, 10'd0,    '0,   1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_INSERT,  64'h8000_0000_0000_0000, 10'd512, '0, 1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_LOOKUP,  ONES,  10'd0,    '0,   1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_RESOLVE, ONES,  10'd0,    ONES, 1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_LOOKUP,  ONES,  10'd0,    '0,   1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_RESOLVE, 64'd1, 10'd1023, '0,   1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_LOOKUP,  64'd1, 10'd0,    '0,   1'b0, STATUS_OK));
    // overwrite drops the resolved mark and handle
    plan.push_back(mk_row(CMD_INSERT,  ONES,  10'd5,    ONES, 1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_LOOKUP,  ONES,  10'd0,    '0,   1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_UNUSED,  64'd1, 10'd0,    '0,   1'b1, STATUS_MISS));
    plan.push_back(mk_row(CMD_LOOKUP,  64'd2, 10'd0,    '0,   1'b1, STATUS_MISS));
    plan.push_back(mk_row(CMD_RESOLVE, 64'd3, 10'd0,    ONES, 1'b1, STATUS_MISS));
    plan.push_back(mk_row(CMD_RESOLVE, 64'h8000_0000_0000_0000, 10'd0,
                          64'h5555_5555_aaaa_aaaa, 1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_LOOKUP,  64'h8000_0000_0000_0000, 10'd0, '0, 1'b0, STATUS_OK));
    plan.push_back(mk_row(CMD_INSERT,  64'h0000_0000_0000_ffff, 10'd341, '0, 1'b0, STATUS_OK));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) send_item(plan[i].stim, plan[i].typed, plan[i].want);
    wait_drained();

    // moderate load, mostly hits on keys already placed
    repeat (800) send_item(random_item(30, 70), 1'b0, '0);
    wait_drained();

    // insert-heavy traffic fills the table further, then mixed traffic over the fuller table
    repeat (900) send_item(random_item(85, 90), 1'b0, '0);
    repeat (300) send_item(random_item(30, 50), 1'b0, '0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d items and %0d checked answers; %0d of %0d slots held at the end.",
             items_sent, answers_checked, keys_held, TABLE_SLOTS);
    $display("Answers: %0d ok, %0d miss, %0d refused as full, %0d zero key.",
             status_tally[STATUS_OK], status_tally[STATUS_MISS],
             status_tally[STATUS_FULL], status_tally[STATUS_ZERO_KEY]);
    if (faults == 0) begin
      $display("PASS pointer_keyed_hash_map");
    end else begin
      $display("FAIL pointer_keyed_hash_map");
    end
    $finish;
  end

endmodule
